[design/hscd_pkg.sv]
// ----------------------------------------------------------------------------
// hscd_pkg
// Shared types, constants and palette lookup for the hires scanline decoder.
// ----------------------------------------------------------------------------
package hscd_pkg;

   localparam int BYTES_PER_LINE_DEFAULT = 40;
   localparam int QUEUE_DEPTH_DEFAULT    = 4;
   localparam int PIXELS_PER_BYTE        = 7;

   localparam logic [2:0] COLOR_BLACK  = 3'd0;
   localparam logic [2:0] COLOR_WHITE  = 3'd1;
   localparam logic [2:0] COLOR_VIOLET = 3'd2;
   localparam logic [2:0] COLOR_GREEN  = 3'd3;
   localparam logic [2:0] COLOR_BLUE   = 3'd4;
   localparam logic [2:0] COLOR_ORANGE = 3'd5;

   localparam logic [23:0] RGB_BLACK  = 24'h000000;
   localparam logic [23:0] RGB_WHITE  = 24'hFFFFFF;
   localparam logic [23:0] RGB_VIOLET = 24'hE314FF;
   localparam logic [23:0] RGB_GREEN  = 24'h1BD34F;
   localparam logic [23:0] RGB_BLUE   = 24'h1873E4;
   localparam logic [23:0] RGB_ORANGE = 24'hF7401E;

   // One byte to be decoded into seven pixels.
   typedef struct packed {
      logic [7:0] byte_bits;
      logic       left_bit;
      logic       right_bit;
      logic [8:0] x_base;
      logic       col_odd;
      logic       color_on;
      logic       run_last;
      logic       line_done;
   } job_type;

   function automatic logic [23:0] color_rgb(input logic [2:0] code);
      logic [23:0] value;
      unique case (code)
         COLOR_WHITE:  value = RGB_WHITE;
         COLOR_VIOLET: value = RGB_VIOLET;
         COLOR_GREEN:  value = RGB_GREEN;
         COLOR_BLUE:   value = RGB_BLUE;
         COLOR_ORANGE: value = RGB_ORANGE;
         default:      value = RGB_BLACK;
      endcase
      return value;
   endfunction

endpackage

[design/hscd_queue.sv]
// ----------------------------------------------------------------------------
// hscd_queue
// Short first-in first-out queue of decode jobs between front and back.
// ----------------------------------------------------------------------------
module hscd_queue #(
   parameter int QUEUE_DEPTH = hscd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  hscd_pkg::job_type push_job,
   output logic              pop_valid,
   input  logic              pop_ready,
   output hscd_pkg::job_type pop_job
);

   localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0]   LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(QUEUE_DEPTH);

   hscd_pkg::job_type entry_mem [QUEUE_DEPTH];

   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != FULL_COUNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = entry_mem[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_mem[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[design/hscd_front.sv]
// ----------------------------------------------------------------------------
// hscd_front
// Accepts display words, tracks the held byte and column, and issues jobs.
// ----------------------------------------------------------------------------
module hscd_front #(
   parameter int BYTES_PER_LINE = hscd_pkg::BYTES_PER_LINE_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_display_byte,
   input  logic              csr_write_enable,
   input  logic              csr_write_data,
   output logic              push_valid,
   input  logic              push_ready,
   output hscd_pkg::job_type push_job
);

   localparam logic [5:0] LAST_COLUMN = 6'(BYTES_PER_LINE - 1);

   logic              color_enable_ff;
   logic [7:0]        held_ff, held_in;
   logic              left_ff, left_in;
   logic [5:0]        column_ff, column_in;
   logic              pend_valid_ff, pend_valid_in;
   hscd_pkg::job_type pend_job_ff, pend_job_in;
   hscd_pkg::job_type held_job;
   logic              accept, line_end;
   logic [5:0]        prev_column;

   assign req_ready   = !pend_valid_ff && push_ready;
   assign accept      = req_valid && req_ready;
   assign line_end    = (column_ff >= LAST_COLUMN);
   assign prev_column = column_ff - 6'd1;

   always_comb begin
      held_job.byte_bits = held_ff;
      held_job.left_bit  = left_ff;
      held_job.right_bit = req_display_byte[0];
      held_job.x_base    = {prev_column, 3'b000} - {3'b000, prev_column};
      held_job.col_odd   = prev_column[0];
      held_job.color_on  = color_enable_ff;
      held_job.run_last  = !line_end;
      held_job.line_done = 1'b0;
   end

   assign push_valid = pend_valid_ff || (accept && (column_ff != '0));
   assign push_job   = pend_valid_ff ? pend_job_ff : held_job;

   always_comb begin
      held_in       = held_ff;
      left_in       = left_ff;
      column_in     = column_ff;
      pend_valid_in = pend_valid_ff && !push_ready;
      pend_job_in   = pend_job_ff;
      if (accept) begin
         if (column_ff == '0) begin
            held_in   = req_display_byte;
            left_in   = 1'b0;
            column_in = 6'd1;
         end else if (line_end) begin
            pend_valid_in         = 1'b1;
            pend_job_in.byte_bits = req_display_byte;
            pend_job_in.left_bit  = held_ff[6];
            pend_job_in.right_bit = 1'b0;
            pend_job_in.x_base    = {column_ff, 3'b000} - {3'b000, column_ff};
            pend_job_in.col_odd   = column_ff[0];
            pend_job_in.color_on  = color_enable_ff;
            pend_job_in.run_last  = 1'b1;
            pend_job_in.line_done = 1'b1;
            held_in               = '0;
            left_in               = 1'b0;
            column_in             = '0;
         end else begin
            left_in   = held_ff[6];
            held_in   = req_display_byte;
            column_in = column_ff + 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_enable_ff <= 1'b0;
         held_ff         <= '0;
         left_ff         <= 1'b0;
         column_ff       <= '0;
         pend_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            color_enable_ff <= csr_write_data;
         end
         held_ff       <= held_in;
         left_ff       <= left_in;
         column_ff     <= column_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_job_ff <= pend_job_in;
   end

endmodule

[design/hscd_back.sv]
// ----------------------------------------------------------------------------
// hscd_back
// Walks the seven pixels of each job and drives the registered pixel output.
// ----------------------------------------------------------------------------
module hscd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  hscd_pkg::job_type pop_job,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [8:0]        rsp_pixel_x,
   output logic [2:0]        rsp_color_code,
   output logic [23:0]       rsp_rgb,
   output logic              rsp_run_last,
   output logic              rsp_line_done
);

   localparam logic [2:0] LAST_PIXEL = 3'(hscd_pkg::PIXELS_PER_BYTE - 1);

   hscd_pkg::job_type job_ff;
   logic              job_valid_ff;
   logic [2:0]        pix_ff;
   logic              out_valid_ff;
   logic [8:0]        out_x_ff;
   logic [2:0]        out_code_ff;
   logic [23:0]       out_rgb_ff;
   logic              out_run_last_ff;
   logic              out_line_done_ff;

   logic       out_load, step, last_pix;
   logic       cur_bit, left_nbr, right_nbr, parity;
   logic [2:0] code;

   assign out_load  = !out_valid_ff || rsp_ready;
   assign step      = job_valid_ff && out_load;
   assign last_pix  = (pix_ff == LAST_PIXEL);
   assign pop_ready = !job_valid_ff || (step && last_pix);

   always_comb begin
      cur_bit   = job_ff.byte_bits[pix_ff];
      left_nbr  = (pix_ff == '0) ? job_ff.left_bit : job_ff.byte_bits[pix_ff - 3'd1];
      right_nbr = last_pix ? job_ff.right_bit : job_ff.byte_bits[pix_ff + 3'd1];
      parity    = pix_ff[0] ^ job_ff.col_odd;
      code      = hscd_pkg::COLOR_BLACK;
      if (!job_ff.color_on) begin
         if (cur_bit) begin
            code = hscd_pkg::COLOR_WHITE;
         end
      end else if (cur_bit) begin
         if (left_nbr || right_nbr) begin
            code = hscd_pkg::COLOR_WHITE;
         end else begin
            code = hscd_pkg::COLOR_VIOLET + {1'b0, job_ff.byte_bits[7], parity};
         end
      end else if (left_nbr && right_nbr) begin
         code = hscd_pkg::COLOR_VIOLET + {1'b0, job_ff.byte_bits[7], !parity};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         pix_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (pop_valid && pop_ready) begin
            job_valid_ff <= 1'b1;
            pix_ff       <= '0;
         end else if (step && last_pix) begin
            job_valid_ff <= 1'b0;
         end else if (step) begin
            pix_ff <= pix_ff + 3'd1;
         end
         if (out_load) begin
            out_valid_ff <= step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop_valid && pop_ready) begin
         job_ff <= pop_job;
      end
      if (step) begin
         out_x_ff         <= job_ff.x_base + {6'd0, pix_ff};
         out_code_ff      <= code;
         out_rgb_ff       <= hscd_pkg::color_rgb(code);
         out_run_last_ff  <= job_ff.run_last && last_pix;
         out_line_done_ff <= job_ff.line_done && last_pix;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_pixel_x    = out_x_ff;
   assign rsp_color_code = out_code_ff;
   assign rsp_rgb        = out_rgb_ff;
   assign rsp_run_last   = out_run_last_ff;
   assign rsp_line_done  = out_line_done_ff;

endmodule

[design/hires_scanline_color_decoder_top.sv]
// ----------------------------------------------------------------------------
// hires_scanline_color_decoder_top
// Decodes hires scanline bytes into artifact-colored pixels.
//
// Channel   Direction  Handshake            Word
// req       in         req_valid/req_ready  display_byte
// rsp       out        rsp_valid/rsp_ready  pixel_x, color_code, rgb, run_last,
//                                           line_done
// csr       in         csr_write_enable     color_enable
//
// The back end emits one pixel per cycle while jobs are queued and rsp_ready is held.
// The first byte of a line yields no pixels; the last yields fourteen.
// Reset is synchronous and needs no clearing pass.
// The job queue lets the input keep filling while the output is stalled.
// ----------------------------------------------------------------------------
module hires_scanline_color_decoder_top #(
   parameter int BYTES_PER_LINE = hscd_pkg::BYTES_PER_LINE_DEFAULT,
   parameter int QUEUE_DEPTH    = hscd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_display_byte,
   input  logic        csr_write_enable,
   input  logic        csr_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [8:0]  rsp_pixel_x,
   output logic [2:0]  rsp_color_code,
   output logic [23:0] rsp_rgb,
   output logic        rsp_run_last,
   output logic        rsp_line_done
);

   logic              push_valid, push_ready;
   hscd_pkg::job_type push_job;
   logic              pop_valid, pop_ready;
   hscd_pkg::job_type pop_job;

   hscd_front #(
      .BYTES_PER_LINE(BYTES_PER_LINE)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_display_byte(req_display_byte),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_job        (push_job)
   );

   hscd_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_job  (push_job),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_job   (pop_job)
   );

   hscd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop_ready     (pop_ready),
      .pop_job       (pop_job),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pixel_x   (rsp_pixel_x),
      .rsp_color_code(rsp_color_code),
      .rsp_rgb       (rsp_rgb),
      .rsp_run_last  (rsp_run_last),
      .rsp_line_done (rsp_line_done)
   );

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// Testbench for hires_scanline_color_decoder_top
// Feeds display bytes through the valid/ready input channel, predicts every
// pixel word the decoder should emit, and compares each accepted pixel word
// field by field with the oldest prediction. The color mode register is
// changed only while the decoder is idle. Both channels idle at random, and
// the output is held off once for a long stretch so that the input backs up.
// ----------------------------------------------------------------------------
typedef struct packed {
   logic [8:0]  x;
   logic [2:0]  code;
   logic [23:0] rgb;
   logic        run_last;
   logic        line_done;
} pixel_word_type;

class hires_pixel_ledger;
   localparam int LINE_BYTES = hscd_pkg::BYTES_PER_LINE_DEFAULT;

   pixel_word_type pending_pixels[$];
   logic [7:0]  held_bits;
   logic        left_bit;
   int          column;
   logic        color_on;
   int          mismatches;
   int          pixels_checked;
   int          lines_closed;

   function new();
      held_bits      = '0;
      left_bit       = 1'b0;
      column         = 0;
      color_on       = 1'b0;
      mismatches     = 0;
      pixels_checked = 0;
      lines_closed   = 0;
   endfunction

   function void decode_pixels(input logic [7:0] bits, input logic left, input logic right,
                               input int col, input logic step_end, input logic line_end);
      pixel_word_type px;
      logic        prev;
      logic        cur;
      logic        nxt;
      logic        tinted;
      logic [1:0]  idx;
      prev = left;
      for (int p = 0; p < hscd_pkg::PIXELS_PER_BYTE; p++) begin
         cur = bits[p];
         nxt = (p < hscd_pkg::PIXELS_PER_BYTE - 1) ? bits[p + 1] : right;
         px.x = 9'(col * hscd_pkg::PIXELS_PER_BYTE + p);
         px.code = hscd_pkg::COLOR_BLACK;
         px.rgb = hscd_pkg::RGB_BLACK;
         px.run_last = step_end && (p == hscd_pkg::PIXELS_PER_BYTE - 1);
         px.line_done = line_end && (p == hscd_pkg::PIXELS_PER_BYTE - 1);
         tinted = 1'b0;
         idx = 2'b00;
         if (!color_on) begin
            if (cur) begin
               px.code = hscd_pkg::COLOR_WHITE;
               px.rgb = hscd_pkg::RGB_WHITE;
            end
         end else if (cur) begin
            if (prev || nxt) begin
               px.code = hscd_pkg::COLOR_WHITE;
               px.rgb = hscd_pkg::RGB_WHITE;
            end else begin
               tinted = 1'b1;
               idx = {bits[7], 1'((p + col) & 1)};
            end
         end else if (prev && nxt) begin
            tinted = 1'b1;
            idx = {bits[7], 1'((p + col + 1) & 1)};
         end
         if (tinted) begin
            case (idx)
               2'd0: begin
                  px.code = hscd_pkg::COLOR_VIOLET;
                  px.rgb = hscd_pkg::RGB_VIOLET;
               end
               2'd1: begin
                  px.code = hscd_pkg::COLOR_GREEN;
                  px.rgb = hscd_pkg::RGB_GREEN;
               end
               2'd2: begin
                  px.code = hscd_pkg::COLOR_BLUE;
                  px.rgb = hscd_pkg::RGB_BLUE;
               end
               default: begin
                  px.code = hscd_pkg::COLOR_ORANGE;
                  px.rgb = hscd_pkg::RGB_ORANGE;
               end
            endcase
         end
         pending_pixels.push_back(px);
         prev = cur;
      end
   endfunction

   function void take_byte(input logic [7:0] b);
      if (column == 0) begin
         held_bits = b;
         left_bit = 1'b0;
         column = 1;
      end else if (column >= LINE_BYTES - 1) begin
         decode_pixels(held_bits, left_bit, b[0], column - 1, 1'b0, 1'b0);
         decode_pixels(b, held_bits[6], 1'b0, column, 1'b1, 1'b1);
         held_bits = '0;
         left_bit = 1'b0;
         column = 0;
      end else begin
         decode_pixels(held_bits, left_bit, b[0], column - 1, 1'b1, 1'b0);
         left_bit = held_bits[6];
         held_bits = b;
         column++;
      end
   endfunction

   function void match_pixel(input pixel_word_type got);
      pixel_word_type want;
      if (pending_pixels.size() == 0) begin
         $error("unexpected pixel word at x %0d", got.x);
         mismatches++;
         return;
      end
      want = pending_pixels.pop_front();
      pixels_checked++;
      if (want.line_done) lines_closed++;
      if (got.x !== want.x) begin
         $error("pixel_x: expected %0d, got %0d", want.x, got.x);
         mismatches++;
      end
      if (got.code !== want.code) begin
         $error("color_code: expected %0d, got %0d", want.code, got.code);
         mismatches++;
      end
      if (got.rgb !== want.rgb) begin
         $error("rgb: expected %06h, got %06h", want.rgb, got.rgb);
         mismatches++;
      end
      if (got.run_last !== want.run_last) begin
         $error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
         mismatches++;
      end
      if (got.line_done !== want.line_done) begin
         $error("line_done: expected %0b, got %0b", want.line_done, got.line_done);
         mismatches++;
      end
   endfunction
endclass

module testbench;
   localparam int LINE_BYTES   = hscd_pkg::BYTES_PER_LINE_DEFAULT;
   localparam int TOTAL_BYTES  = 370;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int SETTLE_WAIT  = 20;
   localparam int HOLD_CYCLES  = 300;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_display_byte;
   logic        csr_write_enable;
   logic        csr_write_data;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [8:0]  rsp_pixel_x;
   logic [2:0]  rsp_color_code;
   logic [23:0] rsp_rgb;
   logic        rsp_run_last;
   logic        rsp_line_done;

   hires_pixel_ledger ledger;
   int  cycles;
   int  bytes_sent;
   int  mode_changes;
   bit  no_idle;
   bit  hold_wanted;

   hires_scanline_color_decoder_top #(
      .BYTES_PER_LINE(LINE_BYTES)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_display_byte(req_display_byte),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_pixel_x(rsp_pixel_x),
      .rsp_color_code(rsp_color_code),
      .rsp_rgb(rsp_rgb),
      .rsp_run_last(rsp_run_last),
      .rsp_line_done(rsp_line_done)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial cycles = 0;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 6);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_display_byte <= b;
      do @(posedge clock); while (!req_ready);
      ledger.take_byte(b);
      bytes_sent++;
   endtask

   task automatic set_color_mode(input logic value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (ledger.pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      ledger.color_on = value;
      mode_changes++;
   endtask

   initial begin : receiver
      int  gap;
      bit  held_off;
      pixel_word_type got;
      held_off = 1'b0;
      rsp_ready <= 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = no_idle ? 0 : $urandom_range(0, 6);
         if (hold_wanted && !held_off) begin
            held_off = 1'b1;
            gap = HOLD_CYCLES;
         end
         @(negedge clock);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got.x = rsp_pixel_x;
         got.code = rsp_color_code;
         got.rgb = rsp_rgb;
         got.run_last = rsp_run_last;
         got.line_done = rsp_line_done;
         ledger.match_pixel(got);
      end
   end

   initial begin : stimulus
      logic [7:0] directed_bytes[25];
      logic [7:0] b;
      int         phase;
      int         phase_len;
      ledger = new();
      bytes_sent = 0;
      mode_changes = 0;
      no_idle = 1'b0;
      hold_wanted = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_display_byte <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data <= 1'b0;
      directed_bytes = '{8'h00, 8'hFF, 8'h7F, 8'h80, 8'h01, 8'h40, 8'h01, 8'h55,
                         8'h2A, 8'hD5, 8'hAA, 8'h08, 8'h88, 8'h05, 8'h85, 8'h7F,
                         8'h00, 8'hFF, 8'h14, 8'h94, 8'h05, 8'h85, 8'h41, 8'hC1,
                         8'h22};
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Artifact colors first, then a monochrome stretch and back, both mid-line.
      set_color_mode(1'b1);
      for (int i = 0; i < 25; i++) begin
         if (i == 13) set_color_mode(1'b0);
         if (i == 19) set_color_mode(1'b1);
         send_byte(directed_bytes[i]);
      end

      phase = 0;
      while (bytes_sent < TOTAL_BYTES) begin
         set_color_mode(phase % 2 == 0);
         no_idle = (phase != 0) && ($urandom_range(0, 3) == 0);
         phase_len = (phase == 0) ? 60 : $urandom_range(20, 80);
         if (phase_len > TOTAL_BYTES - bytes_sent) phase_len = TOTAL_BYTES - bytes_sent;
         for (int i = 0; i < phase_len; i++) begin
            if (phase == 0 && i == 5) hold_wanted = 1'b1;
            case ($urandom_range(0, 9))
               0:       b = 8'h00;
               1:       b = {$urandom_range(0, 1) == 1, 7'h7F};
               2:       b = {$urandom_range(0, 1) == 1, 7'h55};
               3:       b = {$urandom_range(0, 1) == 1, 7'h2A};
               4:       b = {$urandom_range(0, 1) == 1, 7'(1 << $urandom_range(0, 6))};
               default: b = 8'($urandom_range(0, 255));
            endcase
            send_byte(b);
         end
         phase++;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (ledger.pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);

      $display("Sent %0d display bytes, checked %0d pixel words, %0d full scanlines.",
               bytes_sent, ledger.pixels_checked, ledger.lines_closed);
      $display("Color mode was written %0d times; the output was held off once.",
               mode_changes);
      if (ledger.mismatches == 0 && ledger.pending_pixels.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

[hires_scanline_color_decoder_top.f]
design/hscd_pkg.sv
design/hscd_queue.sv
design/hscd_front.sv
design/hscd_back.sv
design/hires_scanline_color_decoder_top.sv
sim/testbench.sv
